FILE: src/adpc_pkg.sv
// Shared types, codes and reset values for the actuator deadband position controller.
// No dependencies; every other file of the block imports this package.
package adpc_pkg;

	// Field widths of the stream payloads.
	localparam int TimeW = 32;
	localparam int PosW  = 12;
	localparam int DutyW = 16;
	localparam int AddrW = 4;
	localparam int DataW = 32;

	// Register reset values.
	localparam logic [TimeW-1:0] TimeoutReset  = 32'd12000;
	localparam logic [PosW-1:0]  DeadbandReset = 12'd10;
	localparam logic             FeedbackReset = 1'b1;
	localparam logic [DutyW-1:0] DutyReset     = 16'd600;

	// Register indexes on the configuration port (byte address 4 * index).
	typedef enum logic [1:0] {
		REG_TIMEOUT  = 2'd0,
		REG_DEADBAND = 2'd1,
		REG_FEEDBACK = 2'd2,
		REG_RUN_DUTY = 2'd3
	} reg_idx_t;

	// Request codes carried in tuser; codes five to seven are ignored.
	typedef enum logic [2:0] {
		REQ_TICK       = 3'd0,
		REQ_SET_TARGET = 3'd1,
		REQ_EXTEND     = 3'd2,
		REQ_RETRACT    = 3'd3,
		REQ_STOP       = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		MODE_IDLE       = 2'd0,
		MODE_EXTENDING  = 2'd1,
		MODE_RETRACTING = 2'd2,
		MODE_FAULT      = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	// Configuration as seen by the control logic.
	typedef struct packed {
		logic [TimeW-1:0] move_timeout_ms;
		logic [PosW-1:0]  deadband;
		logic             position_feedback_on;
		logic [DutyW-1:0] run_duty;
	} cfg_t;

	// One request as held in the input register.
	typedef struct packed {
		req_t             req_type;
		logic [TimeW-1:0] now_ms;
		logic [PosW-1:0]  position_sample;
		logic [PosW-1:0]  target_position;
	} item_t;

	// Controller state; direction, duty and mode are also the reported result.
	typedef struct packed {
		mode_t            mode;
		logic [TimeW-1:0] move_start_time;
		logic [PosW-1:0]  target_store;
		dir_t             drive_dir;
		logic [DutyW-1:0] drive_duty;
	} ctrl_state_t;

endpackage

FILE: src/adpc_regs.sv
// Configuration register file with an APB-style access port.
// Depends on adpc_pkg for register indexes, widths and reset values.
module adpc_regs
	import adpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign cfg    = cfg_q;

	// Register writes complete on the access phase of a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_timeout_ms      <= TimeoutReset;
			cfg_q.deadband             <= DeadbandReset;
			cfg_q.position_feedback_on <= FeedbackReset;
			cfg_q.run_duty             <= DutyReset;
		end else if (wr_en) begin
			case (idx)
				REG_TIMEOUT:  cfg_q.move_timeout_ms      <= pwdata;
				REG_DEADBAND: cfg_q.deadband             <= pwdata[PosW-1:0];
				REG_FEEDBACK: cfg_q.position_feedback_on <= pwdata[0];
				REG_RUN_DUTY: cfg_q.run_duty             <= pwdata[DutyW-1:0];
				default: ;
			endcase
		end
	end

	// Read data, zero-extended to the bus width.
	always_comb begin
		case (idx)
			REG_TIMEOUT:  prdata = cfg_q.move_timeout_ms;
			REG_DEADBAND: prdata = {{(DataW-PosW){1'b0}}, cfg_q.deadband};
			REG_FEEDBACK: prdata = {{(DataW-1){1'b0}}, cfg_q.position_feedback_on};
			REG_RUN_DUTY: prdata = {{(DataW-DutyW){1'b0}}, cfg_q.run_duty};
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: src/adpc_step.sv
// Next-state logic: applies one request to the controller state.
// Depends on adpc_pkg for the request, mode and direction codes and the state struct.
module adpc_step
	import adpc_pkg::*;
(
	input  cfg_t        cfg,
	input  item_t       item,
	input  ctrl_state_t cur,
	output ctrl_state_t nxt
);

	logic [PosW-1:0]  band_tgt;
	logic [PosW:0]    pos_hi;
	logic [PosW:0]    tgt_hi;
	logic             below_band;
	logic             above_band;
	logic [TimeW-1:0] elapsed;
	logic             timed_out;
	logic             moving;
	logic             pos_bad;

	// A new target is compared at once; otherwise the stored one is used.
	assign band_tgt   = (item.req_type == REQ_SET_TARGET) ? item.target_position
	                                                      : cur.target_store;
	assign pos_hi     = {1'b0, item.position_sample} + {1'b0, cfg.deadband};
	assign tgt_hi     = {1'b0, band_tgt} + {1'b0, cfg.deadband};
	assign below_band = pos_hi < {1'b0, band_tgt};
	assign above_band = {1'b0, item.position_sample} > tgt_hi;

	// Elapsed time wraps modulo 2^32, as the time stamp does.
	assign elapsed   = item.now_ms - cur.move_start_time;
	assign timed_out = elapsed > cfg.move_timeout_ms;
	assign moving    = (cur.mode == MODE_EXTENDING) || (cur.mode == MODE_RETRACTING);
	assign pos_bad   = (item.position_sample == '0);

	always_comb begin
		nxt = cur;
		case (item.req_type)
			REQ_TICK: begin
				if (moving) begin
					if (timed_out || (cfg.position_feedback_on && pos_bad)) begin
						nxt.mode       = MODE_FAULT;
						nxt.drive_dir  = DIR_STOP;
						nxt.drive_duty = '0;
					end else if (cfg.position_feedback_on) begin
						// A move already heading the right way keeps its timer.
						if (below_band) begin
							if (cur.mode != MODE_EXTENDING) begin
								nxt.mode            = MODE_EXTENDING;
								nxt.move_start_time = item.now_ms;
								nxt.drive_dir       = DIR_FWD;
								nxt.drive_duty      = cfg.run_duty;
							end
						end else if (above_band) begin
							if (cur.mode != MODE_RETRACTING) begin
								nxt.mode            = MODE_RETRACTING;
								nxt.move_start_time = item.now_ms;
								nxt.drive_dir       = DIR_REV;
								nxt.drive_duty      = cfg.run_duty;
							end
						end else begin
							nxt.mode       = MODE_IDLE;
							nxt.drive_dir  = DIR_STOP;
							nxt.drive_duty = '0;
						end
					end
				end
			end
			REQ_SET_TARGET: begin
				// The target is kept even when the sample is a read failure.
				nxt.target_store = item.target_position;
				if (pos_bad) begin
					nxt.mode       = MODE_FAULT;
					nxt.drive_dir  = DIR_STOP;
					nxt.drive_duty = '0;
				end else if (below_band) begin
					nxt.mode            = MODE_EXTENDING;
					nxt.move_start_time = item.now_ms;
					nxt.drive_dir       = DIR_FWD;
					nxt.drive_duty      = cfg.run_duty;
				end else if (above_band) begin
					nxt.mode            = MODE_RETRACTING;
					nxt.move_start_time = item.now_ms;
					nxt.drive_dir       = DIR_REV;
					nxt.drive_duty      = cfg.run_duty;
				end else begin
					nxt.mode       = MODE_IDLE;
					nxt.drive_dir  = DIR_STOP;
					nxt.drive_duty = '0;
				end
			end
			REQ_EXTEND: begin
				nxt.mode            = MODE_EXTENDING;
				nxt.move_start_time = item.now_ms;
				nxt.drive_dir       = DIR_FWD;
				nxt.drive_duty      = cfg.run_duty;
			end
			REQ_RETRACT: begin
				nxt.mode            = MODE_RETRACTING;
				nxt.move_start_time = item.now_ms;
				nxt.drive_dir       = DIR_REV;
				nxt.drive_duty      = cfg.run_duty;
			end
			REQ_STOP: begin
				nxt.mode       = MODE_IDLE;
				nxt.drive_dir  = DIR_STOP;
				nxt.drive_duty = '0;
			end
			default: ;
		endcase
	end

endmodule

FILE: src/actuator_deadband_position_control_core.sv
// Top level of the actuator deadband position controller.
// Depends on adpc_pkg, adpc_regs and adpc_step.
//
// Channel   Direction  Carries
// s_*       in         one request: tuser = req_type, tdata = time, sample, target
// m_*       out        one result per request: direction, duty, mode
// APB       in/out     four configuration registers at byte addresses 0, 4, 8, 12
//
// A request is registered on its transfer and evaluated once the result register is
// free, when the controller state and the result register load together. One request
// per cycle is sustained while m_tready is high: the input register refills as its
// request moves on, and the only stall is the result register held by m_tready low.
// Reset (arst_n low) gives mode idle, motor stopped, duty zero, timer and target zero,
// and the registers their documented defaults.
module actuator_deadband_position_control_core
	import adpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// Request stream.
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [55:0]      s_tdata,  // [31:0] now_ms, [43:32] position_sample,
	                                   // [55:44] target_position
	input  logic [2:0]       s_tuser,  // [2:0] req_type
	// Result stream.
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,  // [1:0] motor_direction, [17:2] motor_duty,
	                                   // [19:18] actuator_mode, [23:20] zero
	// Configuration port.
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	cfg_t        cfg;
	item_t       item_s1;
	logic        valid_s1;
	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        advance;

	adpc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	adpc_step u_step (
		.cfg (cfg),
		.item(item_s1),
		.cur (state_q),
		.nxt (state_nxt)
	);

	// The held request moves on once the result register is free.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type        <= req_t'(s_tuser);
			item_s1.now_ms          <= s_tdata[31:0];
			item_s1.position_sample <= s_tdata[43:32];
			item_s1.target_position <= s_tdata[55:44];
		end
	end

	// Controller state doubles as the result register: it only changes when the
	// previous result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode            <= MODE_IDLE;
			state_q.move_start_time <= '0;
			state_q.target_store    <= '0;
			state_q.drive_dir       <= DIR_STOP;
			state_q.drive_duty      <= '0;
			out_valid_q             <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, state_q.mode, state_q.drive_duty, state_q.drive_dir};

endmodule

FILE: src/adpc_checker.sv
// Port-level checks on the result stream of the actuator controller, bound to the top.
// Depends on adpc_pkg for the mode and direction codes.
module adpc_checker
	import adpc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic [1:0]  dir;
	logic [15:0] duty;
	logic [1:0]  mode;

	assign dir  = m_tdata[1:0];
	assign duty = m_tdata[17:2];
	assign mode = m_tdata[19:18];

	// A stopped motor never carries a duty.
	a_stop_no_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (dir == DIR_STOP) |-> (duty == '0))
		else $error("motor stopped with non-zero duty");

	// Idle and fault modes always stop the motor.
	a_rest_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((mode == MODE_IDLE) || (mode == MODE_FAULT)) |-> (dir == DIR_STOP))
		else $error("motor driven while idle or in fault");

	// Moving modes drive the motor the matching way.
	a_mode_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((mode == MODE_EXTENDING) || (mode == MODE_RETRACTING))
		|-> (dir == mode))
		else $error("motor direction disagrees with mode");

	// A result that is not taken stays as it is.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind actuator_deadband_position_control_core adpc_checker u_adpc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

FILE: test/adpc_result_checker.sv
// Result checker for the actuator deadband position controller: it follows the request,
// result and configuration channels, predicts each result and compares it field by field.
// Depends on adpc_pkg for widths, request codes, modes and directions.
module adpc_result_checker
	import adpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [55:0]      s_tdata,  // [31:0] now_ms, [43:32] position_sample,
	                                   // [55:44] target_position
	input  logic [2:0]       s_tuser,  // [2:0] req_type
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [23:0]      m_tdata,  // [1:0] motor_direction, [17:2] motor_duty,
	                                   // [19:18] actuator_mode, [23:20] zero
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	input  logic             pready,
	output int               mismatches,
	output int               outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		dir_t             dir;
		logic [DutyW-1:0] duty;
		mode_t            mode;
	} drive_report_t;

	// Register copies as the controller should hold them.
	logic [TimeW-1:0] cfg_timeout;
	logic [PosW-1:0]  cfg_band;
	logic             cfg_feedback;
	logic [DutyW-1:0] cfg_duty;

	// Predicted controller state.
	mode_t            ctl_mode;
	logic [TimeW-1:0] ctl_start;
	logic [PosW-1:0]  ctl_target;
	dir_t             ctl_dir;
	logic [DutyW-1:0] ctl_duty;

	drive_report_t drive_expected[$];

	function automatic void begin_motion(mode_t m, dir_t d, logic [TimeW-1:0] now);
		ctl_mode  = m;
		ctl_start = now;
		ctl_dir   = d;
		ctl_duty  = cfg_duty;
	endfunction

	function automatic void halt_motion(mode_t m);
		ctl_mode = m;
		ctl_dir  = DIR_STOP;
		ctl_duty = '0;
	endfunction

	// Which way the target lies from a sample, with the stop band counted as no way.
	function automatic dir_t band_side(logic [PosW-1:0] pos);
		int p;
		int t;
		int b;
		p = int'(pos);
		t = int'(ctl_target);
		b = int'(cfg_band);
		if (p + b < t)
			return DIR_FWD;
		if (p > t + b)
			return DIR_REV;
		return DIR_STOP;
	endfunction

	// Steer towards the target; a move starts only on a change of direction or with restart.
	function automatic void steer(logic [PosW-1:0] pos, logic [TimeW-1:0] now,
			bit restart);
		dir_t side;
		side = band_side(pos);
		if (side == DIR_FWD) begin
			if (restart || ctl_mode != MODE_EXTENDING)
				begin_motion(MODE_EXTENDING, DIR_FWD, now);
		end else if (side == DIR_REV) begin
			if (restart || ctl_mode != MODE_RETRACTING)
				begin_motion(MODE_RETRACTING, DIR_REV, now);
		end else begin
			halt_motion(MODE_IDLE);
		end
	endfunction

	// Apply one request to the predicted state and return the report it leads to.
	function automatic drive_report_t advance_controller(logic [2:0] req,
			logic [TimeW-1:0] now, logic [PosW-1:0] pos, logic [PosW-1:0] tgt);
		drive_report_t rep;
		logic [TimeW-1:0] elapsed;
		elapsed = now - ctl_start;
		case (req)
			REQ_TICK: begin
				if (ctl_mode == MODE_EXTENDING || ctl_mode == MODE_RETRACTING) begin
					if (elapsed > cfg_timeout)
						halt_motion(MODE_FAULT);
					else if (cfg_feedback) begin
						if (pos == '0)
							halt_motion(MODE_FAULT);
						else
							steer(pos, now, 1'b0);
					end
				end
			end
			REQ_SET_TARGET: begin
				ctl_target = tgt;
				if (pos == '0)
					halt_motion(MODE_FAULT);
				else
					steer(pos, now, 1'b1);
			end
			REQ_EXTEND:  begin_motion(MODE_EXTENDING, DIR_FWD, now);
			REQ_RETRACT: begin_motion(MODE_RETRACTING, DIR_REV, now);
			REQ_STOP:    halt_motion(MODE_IDLE);
			default: ;
		endcase
		rep.dir  = ctl_dir;
		rep.duty = ctl_duty;
		rep.mode = ctl_mode;
		return rep;
	endfunction

	function automatic void compare_report(drive_report_t want, logic [23:0] got);
		if (got[1:0] !== want.dir) begin
			$error("motor_direction: expected %0d, got %0d", want.dir, got[1:0]);
			mismatches++;
		end
		if (got[17:2] !== want.duty) begin
			$error("motor_duty: expected %0d, got %0d", want.duty, got[17:2]);
			mismatches++;
		end
		if (got[19:18] !== want.mode) begin
			$error("actuator_mode: expected %0d, got %0d", want.mode, got[19:18]);
			mismatches++;
		end
	endfunction

	// Track register writes and transfers on both streams.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_timeout  = TimeoutReset;
			cfg_band     = DeadbandReset;
			cfg_feedback = FeedbackReset;
			cfg_duty     = DutyReset;
			ctl_mode     = MODE_IDLE;
			ctl_start    = '0;
			ctl_target   = '0;
			ctl_dir      = DIR_STOP;
			ctl_duty     = '0;
			drive_expected.delete();
			mismatches   = 0;
			outstanding  = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[AddrW-1:2]))
					REG_TIMEOUT:  cfg_timeout  = pwdata[TimeW-1:0];
					REG_DEADBAND: cfg_band     = pwdata[PosW-1:0];
					REG_FEEDBACK: cfg_feedback = pwdata[0];
					REG_RUN_DUTY: cfg_duty     = pwdata[DutyW-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				drive_expected.push_back(advance_controller(s_tuser, s_tdata[31:0],
					s_tdata[43:32], s_tdata[55:44]));
			if (m_tvalid && m_tready) begin
				if (drive_expected.size() == 0) begin
					$error("result transfer with no request waiting: %h", m_tdata);
					mismatches++;
				end else begin
					compare_report(drive_expected.pop_front(), m_tdata);
				end
			end
			outstanding = drive_expected.size();
		end
	end

endmodule

FILE: test/actuator_deadband_position_control_core_tb.sv
// Testbench top for the actuator deadband position controller: clock, reset, register
// writes, request stimulus and result back-pressure, and the final verdict.
// Depends on adpc_pkg, the core under test and adpc_result_checker.
module actuator_deadband_position_control_core_tb;

	import adpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit = 2000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [55:0]      s_tdata = '0;  // [31:0] now_ms, [43:32] position_sample,
	                                 // [55:44] target_position
	logic [2:0]       s_tuser = '0;  // [2:0] req_type
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [23:0]      m_tdata;       // [1:0] motor_direction, [17:2] motor_duty,
	                                 // [19:18] actuator_mode, [23:20] zero
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic             pready;

	int               mismatches;
	int               outstanding;

	logic [TimeW-1:0] ms_now = '0;
	bit               idle_on = 1'b1;
	int               hold_ask = 0;
	int               hold_left = 0;

	actuator_deadband_position_control_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	adpc_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Result side: random stalls, plus a long hold-off when one is asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_ask != 0) begin
				hold_left = hold_ask;
				hold_ask = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(99) < 24);
			end
		end
	end

	// Give up once no transfer of any kind has happened for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	// Register write: a setup phase, then an access phase held until pready.
	task automatic write_register(reg_idx_t idx, logic [DataW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrW'(idx) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one request, the clock having moved on by gap ms, and wait for its transfer.
	task automatic send_request(logic [2:0] req, logic [TimeW-1:0] gap,
			logic [PosW-1:0] pos, logic [PosW-1:0] tgt);
		while (idle_on && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		ms_now = ms_now + gap;
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {tgt, pos, ms_now};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Stop offering and let every outstanding result come back.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Mostly short gaps; now and then a jump that spans the whole time range.
	function automatic logic [TimeW-1:0] next_gap();
		if ($urandom_range(15) == 0)
			return $urandom;
		return $urandom_range(0, 1500);
	endfunction

	// Move a simulated position towards the goal, sometimes overshooting it.
	function automatic logic [PosW-1:0] approach(logic [PosW-1:0] pos,
			logic [PosW-1:0] goal);
		int p;
		int stride;
		p = int'(pos);
		stride = $urandom_range(0, 400);
		if (goal > pos)
			p = p + stride;
		else
			p = p - stride;
		if (p < 1)
			p = 1;
		if (p > 4095)
			p = 4095;
		return PosW'(p);
	endfunction

	// Target runs: a new target followed by ticks that close in on it, with noise.
	task automatic drive_target_runs(int budget);
		int sent;
		int roll;
		logic [PosW-1:0] pos;
		logic [PosW-1:0] goal;
		sent = 0;
		while (sent < budget) begin
			goal = PosW'($urandom_range(0, 4095));
			pos = PosW'($urandom_range(1, 4095));
			send_request(REQ_SET_TARGET, next_gap(), pos, goal);
			sent++;
			repeat ($urandom_range(2, 10)) begin
				roll = $urandom_range(99);
				if (roll < 5) begin
					// Failed position read.
					send_request(REQ_TICK, next_gap(), '0, PosW'($urandom));
				end else if (roll < 8) begin
					send_request(REQ_SET_TARGET, next_gap(),
						PosW'($urandom_range(0, 4095)), PosW'($urandom));
				end else if (roll < 16) begin
					send_request(3'(int'(REQ_EXTEND) + $urandom_range(0, 2)), next_gap(),
						PosW'($urandom), PosW'($urandom));
				end else if (roll < 19) begin
					send_request(3'(int'(REQ_STOP) + $urandom_range(1, 3)), next_gap(),
						PosW'($urandom), PosW'($urandom));
				end else begin
					pos = approach(pos, goal);
					send_request(REQ_TICK, next_gap(), pos, PosW'($urandom));
				end
				sent++;
			end
		end
	endtask

	initial begin
		int phase;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests on the reset configuration.
		send_request(REQ_TICK, 0, 12'd4095, 12'd4095);
		send_request(REQ_SET_TARGET, 5, 12'd100, 12'd2000);
		send_request(REQ_TICK, 100, 12'd1500, 12'd0);
		send_request(REQ_TICK, 100, 12'd2500, 12'd0);
		send_request(REQ_TICK, 100, 12'd1995, 12'd0);
		send_request(REQ_SET_TARGET, 1, 12'd4095, 12'd4095);
		send_request(REQ_SET_TARGET, 1, 12'd0, 12'd0);
		send_request(REQ_TICK, 1, 12'd500, 12'd0);
		send_request(REQ_EXTEND, 1, 12'd0, 12'd0);
		send_request(REQ_TICK, 1, 12'd0, 12'd0);
		send_request(REQ_RETRACT, 1, 12'd0, 12'd0);
		// Elapsed time equal to the timeout still runs; one more millisecond faults.
		send_request(REQ_TICK, 12000, 12'd4095, 12'd0);
		send_request(REQ_TICK, 1, 12'd4095, 12'd0);
		send_request(REQ_EXTEND, 1, 12'd4095, 12'd4095);
		send_request(REQ_STOP, 1, 12'd4095, 12'd4095);
		for (int k = 1; k <= 3; k++)
			send_request(3'(int'(REQ_STOP) + k), 1, 12'd0, 12'd4095);
		// Edges of the stop band at both ends of the range.
		send_request(REQ_SET_TARGET, 1, 12'd10, 12'd0);
		send_request(REQ_SET_TARGET, 1, 12'd11, 12'd0);
		send_request(REQ_SET_TARGET, 1, 12'd4085, 12'd4095);
		send_request(REQ_SET_TARGET, 1, 12'd4084, 12'd4095);
		send_request(REQ_SET_TARGET, 50, 12'd4084, 12'd4095);
		// Elapsed time across the wrap of the millisecond counter.
		send_request(REQ_EXTEND, 32'hFFFF_FF00 - ms_now, 12'd100, 12'd0);
		send_request(REQ_TICK, 32'h0000_0200, 12'd100, 12'd0);

		// A duty change does not touch a running motor; without feedback a tick
		// ignores even a failed read.
		settle_block();
		write_register(REG_RUN_DUTY, 32'd1234);
		send_request(REQ_TICK, 10, 12'd4000, 12'd0);
		settle_block();
		write_register(REG_FEEDBACK, 32'd0);
		send_request(REQ_TICK, 10, 12'd0, 12'd0);
		send_request(REQ_EXTEND, 10, 12'd0, 12'd0);

		// Random target runs over several register settings.
		for (phase = 0; phase < 5; phase++) begin
			settle_block();
			case (phase)
				0: begin
					write_register(REG_TIMEOUT, $urandom_range(500, 20000));
					write_register(REG_DEADBAND, $urandom_range(0, 40));
					write_register(REG_FEEDBACK, 32'd1);
					write_register(REG_RUN_DUTY, $urandom_range(0, 65535));
				end
				1: begin
					write_register(REG_TIMEOUT, 32'd0);
					write_register(REG_DEADBAND, 32'd0);
					write_register(REG_RUN_DUTY, 32'd65535);
				end
				2: begin
					write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
					write_register(REG_DEADBAND, 32'd4095);
					write_register(REG_FEEDBACK, 32'd0);
					write_register(REG_RUN_DUTY, 32'd0);
				end
				3: begin
					write_register(REG_TIMEOUT, $urandom_range(100, 5000));
					write_register(REG_DEADBAND, $urandom_range(0, 200));
					write_register(REG_FEEDBACK, 32'd1);
					write_register(REG_RUN_DUTY, $urandom_range(0, 65535));
				end
				default: begin
					write_register(REG_TIMEOUT, $urandom_range(0, 3000));
					write_register(REG_DEADBAND, $urandom_range(0, 4095));
					write_register(REG_FEEDBACK, $urandom_range(0, 1));
					write_register(REG_RUN_DUTY, $urandom_range(0, 65535));
				end
			endcase
			// One phase runs flat out and starts with a long result hold-off.
			idle_on = (phase != 3);
			if (phase == 3)
				hold_ask = 80;
			drive_target_runs(76);
		end

		settle_block();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
